[rtl/core/led_bar_matrix_serial_driver_core_assert.svh]
// Assertion macros used by the checker file of the LED bar matrix driver.
`ifndef LED_BAR_MATRIX_SERIAL_DRIVER_CORE_ASSERT_SVH
`define LED_BAR_MATRIX_SERIAL_DRIVER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is low.
`define LBMSD_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is low.
`define LBMSD_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/lbmsd_pkg.sv]
// Types, constants and codes of the LED bar matrix serial driver.
package lbmsd_pkg;

    localparam int NUM_COLUMNS = 10;
    localparam int NUM_ROWS    = 10;

    localparam int COL_W     = 4;
    localparam int ROW_W     = 4;
    localparam int COL_IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0]  RST_ONE_HIGH   = 8'd56;
    localparam logic [7:0]  RST_ONE_LOW    = 8'd27;
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd27;
    localparam logic [7:0]  RST_ZERO_LOW   = 8'd56;
    localparam logic [15:0] RST_LATCH      = 16'd4200;
    localparam logic [3:0]  RST_GREEN_ROWS = 4'd4;
    localparam logic [3:0]  RST_ORANGE_ROWS = 4'd8;

    localparam logic [7:0] BYTE_FULL   = 8'd255;
    localparam logic [7:0] BYTE_ORANGE = 8'd165;
    localparam logic [7:0] BYTE_OFF    = 8'd0;

    typedef enum logic [1:0] {
        FN_SET_LEVEL = 2'd0,
        FN_START     = 2'd1,
        FN_TICK      = 2'd2,
        FN_NONE      = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CH_GREEN = 2'd0,
        CH_RED   = 2'd1,
        CH_BLUE  = 2'd2
    } t_channel;

    typedef enum logic [2:0] {
        CFG_ONE_HIGH    = 3'd0,
        CFG_ONE_LOW     = 3'd1,
        CFG_ZERO_HIGH   = 3'd2,
        CFG_ZERO_LOW    = 3'd3,
        CFG_LATCH       = 3'd4,
        CFG_GREEN_ROWS  = 3'd5,
        CFG_ORANGE_ROWS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       func;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic accepted;
    } t_out_item;

endpackage

[rtl/core/lbmsd_stream_if.sv]
// Valid/ready stream interfaces for the input and result channels.
interface lbmsd_in_if import lbmsd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lbmsd_out_if import lbmsd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/core/led_bar_matrix_serial_driver_core.sv]
// Top level of the LED bar matrix serial driver with its register port.
//
// The block takes one input beat per clock while input ready is high and returns exactly
// one result beat for each, registered in the output buffer at the accepting edge. All
// state for a beat (column levels, frame position and tick counter) is updated then too;
// the rate is set by the combinational level lookup, bit select and tick compare that form
// the frame walker. Results wait in a two-entry output buffer, so input beats keep
// flowing while one result is held; input ready drops only when both entries are full.
// Column levels reset to zero at once, with no clearing pass. Registers are written over
// the APB port at byte address four times their index and read back there.
module led_bar_matrix_serial_driver_core import lbmsd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lbmsd_in_if.sink              i_in,
    lbmsd_out_if.source           o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0]  r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic [15:0] r_latch;
    logic [3:0]  r_green_rows, r_orange_rows;

    logic [ROW_W-1:0] r_levels [NUM_COLUMNS];
    logic [ROW_W-1:0] n_levels [NUM_COLUMNS];
    t_phase           r_phase, n_phase;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_chan, n_chan;
    logic [2:0]       r_bit, n_bit;
    logic [15:0]      r_tick, n_tick;

    t_out_item  r_q [2];
    logic [1:0] r_cnt;

    t_out_item  res;
    logic       in_acc, out_pop, cfg_wr;
    logic [2:0] cfg_idx;
    logic [1:0] wpos;

    logic [ROW_W-1:0] cur_level;
    logic [7:0]       pix_byte;
    logic             pix_bit;
    logic [7:0]       hi_ticks, lo_ticks;
    logic [8:0]       bit_len;
    logic [15:0]      tick_inc;
    logic [15:0]      latch_eff;
    logic             busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high    <= RST_ONE_HIGH;
            r_one_low     <= RST_ONE_LOW;
            r_zero_high   <= RST_ZERO_HIGH;
            r_zero_low    <= RST_ZERO_LOW;
            r_latch       <= RST_LATCH;
            r_green_rows  <= RST_GREEN_ROWS;
            r_orange_rows <= RST_ORANGE_ROWS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_ONE_HIGH:    r_one_high    <= pwdata[7:0];
                CFG_ONE_LOW:     r_one_low     <= pwdata[7:0];
                CFG_ZERO_HIGH:   r_zero_high   <= pwdata[7:0];
                CFG_ZERO_LOW:    r_zero_low    <= pwdata[7:0];
                CFG_LATCH:       r_latch       <= pwdata[15:0];
                CFG_GREEN_ROWS:  r_green_rows  <= pwdata[3:0];
                CFG_ORANGE_ROWS: r_orange_rows <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_ONE_HIGH:    prdata = {24'd0, r_one_high};
            CFG_ONE_LOW:     prdata = {24'd0, r_one_low};
            CFG_ZERO_HIGH:   prdata = {24'd0, r_zero_high};
            CFG_ZERO_LOW:    prdata = {24'd0, r_zero_low};
            CFG_LATCH:       prdata = {16'd0, r_latch};
            CFG_GREEN_ROWS:  prdata = {28'd0, r_green_rows};
            CFG_ORANGE_ROWS: prdata = {28'd0, r_orange_rows};
            default:         prdata = '0;
        endcase
    end

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_pop = o_out.valid & o_out.ready;
    assign busy    = (r_phase != PH_IDLE);

    assign cur_level = r_levels[r_col[COL_IDX_W-1:0]];

    always_comb begin
        pix_byte = BYTE_OFF;
        if (r_row < cur_level) begin
            if (r_row < r_green_rows) begin
                pix_byte = (r_chan == CH_GREEN) ? BYTE_FULL : BYTE_OFF;
            end else if (r_row < r_orange_rows) begin
                unique case (r_chan)
                    CH_GREEN: pix_byte = BYTE_ORANGE;
                    CH_RED:   pix_byte = BYTE_FULL;
                    default:  pix_byte = BYTE_OFF;
                endcase
            end else begin
                pix_byte = (r_chan == CH_RED) ? BYTE_FULL : BYTE_OFF;
            end
        end
    end

    assign pix_bit   = pix_byte[3'd7 - r_bit];
    assign hi_ticks  = pix_bit ? r_one_high : r_zero_high;
    assign lo_ticks  = pix_bit ? r_one_low  : r_zero_low;
    assign bit_len   = {1'b0, hi_ticks} + {1'b0, lo_ticks};
    assign tick_inc  = r_tick + 16'd1;
    assign latch_eff = (r_latch != 16'd0) ? r_latch : 16'd1;

    // Next frame state for the beat at the input.
    always_comb begin
        n_levels = r_levels;
        n_phase  = r_phase;
        n_col    = r_col;
        n_row    = r_row;
        n_chan   = r_chan;
        n_bit    = r_bit;
        n_tick   = r_tick;
        unique case (t_func'(i_in.data.func))
            FN_SET_LEVEL: begin
                if (!busy && ({1'b0, i_in.data.column} < (COL_W+1)'(NUM_COLUMNS))
                        && ({1'b0, i_in.data.level} <= (ROW_W+1)'(NUM_ROWS))) begin
                    n_levels[i_in.data.column[COL_IDX_W-1:0]] = i_in.data.level;
                end
            end
            FN_START: begin
                if (!busy) begin
                    n_phase = PH_SEND;
                    n_col   = '0;
                    n_row   = '0;
                    n_chan  = CH_GREEN;
                    n_bit   = '0;
                    n_tick  = '0;
                end
            end
            FN_TICK: begin
                if (r_phase == PH_SEND) begin
                    n_tick = tick_inc;
                    if (tick_inc >= {7'd0, bit_len}) begin
                        n_tick = '0;
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1;
                        end else begin
                            n_bit = '0;
                            if (r_chan != CH_BLUE) begin
                                n_chan = r_chan + 2'd1;
                            end else begin
                                n_chan = CH_GREEN;
                                if (({1'b0, r_row} + 1'b1) < (ROW_W+1)'(NUM_ROWS)) begin
                                    n_row = r_row + 1'b1;
                                end else begin
                                    n_row = '0;
                                    if (({1'b0, r_col} + 1'b1)
                                            < (COL_W+1)'(NUM_COLUMNS)) begin
                                        n_col = r_col + 1'b1;
                                    end else begin
                                        n_col   = '0;
                                        n_phase = PH_LATCH;
                                    end
                                end
                            end
                        end
                    end
                end else if (r_phase == PH_LATCH) begin
                    n_tick = tick_inc;
                    if (tick_inc >= latch_eff) begin
                        n_tick  = '0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields for the beat at the input.
    always_comb begin
        res.line_level = 1'b0;
        res.frame_done = 1'b0;
        res.accepted   = 1'b0;
        res.busy_res   = (n_phase != PH_IDLE);
        unique case (t_func'(i_in.data.func))
            FN_SET_LEVEL: begin
                res.accepted = !busy
                    && ({1'b0, i_in.data.column} < (COL_W+1)'(NUM_COLUMNS))
                    && ({1'b0, i_in.data.level} <= (ROW_W+1)'(NUM_ROWS));
            end
            FN_START: begin
                res.accepted = !busy;
            end
            FN_TICK: begin
                if (r_phase == PH_SEND) begin
                    res.line_level = (r_tick < {8'd0, hi_ticks});
                end
                res.frame_done = (r_phase == PH_LATCH) && (n_phase == PH_IDLE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                r_levels[i] <= '0;
            end
            r_phase <= PH_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_chan  <= CH_GREEN;
            r_bit   <= '0;
            r_tick  <= '0;
        end else if (in_acc) begin
            r_levels <= n_levels;
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_chan   <= n_chan;
            r_bit    <= n_bit;
            r_tick   <= n_tick;
        end
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_q[0];
    assign wpos        = r_cnt - {1'b0, out_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, in_acc} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (wpos == 2'd0)) begin
            r_q[0] <= res;
        end else if (out_pop) begin
            r_q[0] <= r_q[1];
        end
        if (in_acc && (wpos == 2'd1)) begin
            r_q[1] <= res;
        end
    end

endmodule

[rtl/core/lbmsd_checker.sv]
// Port-level checker of the LED bar matrix driver and its bind to the top level.
`include "led_bar_matrix_serial_driver_core_assert.svh"

module lbmsd_checker import lbmsd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    `LBMSD_ASSERT_RUN(a_out_hold, (i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)), "stalled result beat changed")
    `LBMSD_ASSERT_RUN(a_done_idle, (i_out_valid && i_out_data.frame_done |-> !i_out_data.busy_res), "frame done reported while busy")
    `LBMSD_ASSERT_RUN(a_acc_no_line, (i_out_valid && i_out_data.accepted |-> !i_out_data.line_level && !i_out_data.frame_done), "accepted beat shows tick activity")
    `LBMSD_ASSERT_ALL(a_rst_empty, (!i_rst_n |=> !i_out_valid), "result beat present after reset")

endmodule

bind led_bar_matrix_serial_driver_core lbmsd_checker u_lbmsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[dv/tb_top.sv]
// Self-checking testbench for the LED bar matrix serial driver: directed table, then one frame.
`timescale 1ns / 1ps

module tb_top;
    import lbmsd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        t_func     fn;
        logic [3:0] col;
        logic [3:0] lvl;
        logic       typed;
        t_out_item  exp;
    } t_dir_row;

    // Expected status is written as {line_level, busy_res, frame_done, accepted}.
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{FN_TICK,      4'd0,  4'd0,  1'b1, 4'b0000},
        '{FN_NONE,      4'd15, 4'd15, 1'b1, 4'b0000},
        '{FN_SET_LEVEL, 4'd0,  4'd0,  1'b1, 4'b0001},
        '{FN_SET_LEVEL, 4'd9,  4'd10, 1'b1, 4'b0001},
        '{FN_SET_LEVEL, 4'd10, 4'd0,  1'b1, 4'b0000},
        '{FN_SET_LEVEL, 4'd15, 4'd15, 1'b1, 4'b0000},
        '{FN_SET_LEVEL, 4'd3,  4'd11, 1'b1, 4'b0000},
        '{FN_SET_LEVEL, 4'd0,  4'd15, 1'b1, 4'b0000},
        '{FN_SET_LEVEL, 4'd1,  4'd5,  1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd2,  4'd3,  1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd4,  4'd8,  1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd5,  4'd9,  1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd6,  4'd1,  1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd7,  4'd10, 1'b0, 4'b0000},
        '{FN_START,     4'd0,  4'd0,  1'b1, 4'b0101},
        '{FN_SET_LEVEL, 4'd1,  4'd2,  1'b1, 4'b0100},
        '{FN_START,     4'd5,  4'd5,  1'b1, 4'b0100},
        '{FN_NONE,      4'd0,  4'd0,  1'b1, 4'b0100},
        '{FN_TICK,      4'd0,  4'd0,  1'b0, 4'b0000},
        '{FN_TICK,      4'd15, 4'd15, 1'b0, 4'b0000},
        '{FN_TICK,      4'd7,  4'd8,  1'b0, 4'b0000},
        '{FN_TICK,      4'd8,  4'd7,  1'b0, 4'b0000},
        '{FN_TICK,      4'd3,  4'd12, 1'b0, 4'b0000},
        '{FN_SET_LEVEL, 4'd10, 4'd15, 1'b1, 4'b0100}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lbmsd_in_if  in_if();
    lbmsd_out_if out_if();

    led_bar_matrix_serial_driver_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  cfg_one_hi   = RST_ONE_HIGH;
    logic [7:0]  cfg_one_lo   = RST_ONE_LOW;
    logic [7:0]  cfg_zero_hi  = RST_ZERO_HIGH;
    logic [7:0]  cfg_zero_lo  = RST_ZERO_LOW;
    logic [15:0] cfg_latch    = RST_LATCH;
    logic [3:0]  cfg_green    = RST_GREEN_ROWS;
    logic [3:0]  cfg_orange   = RST_ORANGE_ROWS;

    logic [3:0]  lvl_mem [NUM_COLUMNS];
    t_phase      walk_phase = PH_IDLE;
    logic [3:0]  walk_col   = '0;
    logic [3:0]  walk_row   = '0;
    logic [1:0]  walk_chan  = '0;
    logic [2:0]  walk_bit   = '0;
    logic [15:0] tick_cnt   = '0;

    t_out_item   pending_status[$];
    int          err_cnt   = 0;
    int          stall_cnt = 0;
    int          pace      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic int draw_gap();
        case (pace)
            1: return 0;
            2: return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 14) : 0;
            default: return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic void apply_cfg(input t_cfg_idx idx, input logic [31:0] val);
        case (idx)
            CFG_ONE_HIGH:    cfg_one_hi  = val[7:0];
            CFG_ONE_LOW:     cfg_one_lo  = val[7:0];
            CFG_ZERO_HIGH:   cfg_zero_hi = val[7:0];
            CFG_ZERO_LOW:    cfg_zero_lo = val[7:0];
            CFG_LATCH:       cfg_latch   = val[15:0];
            CFG_GREEN_ROWS:  cfg_green   = val[3:0];
            CFG_ORANGE_ROWS: cfg_orange  = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] color_byte(input logic [3:0] col, input logic [3:0] row,
                                              input logic [1:0] chan);
        if (row >= lvl_mem[col]) return BYTE_OFF;
        if (row < cfg_green) return (chan == CH_GREEN) ? BYTE_FULL : BYTE_OFF;
        if (row < cfg_orange) begin
            if (chan == CH_GREEN) return BYTE_ORANGE;
            return (chan == CH_RED) ? BYTE_FULL : BYTE_OFF;
        end
        return (chan == CH_RED) ? BYTE_FULL : BYTE_OFF;
    endfunction

    function automatic void next_bit();
        tick_cnt = '0;
        if (walk_bit < 3'd7) begin
            walk_bit++;
        end else begin
            walk_bit = '0;
            if (walk_chan < CH_BLUE) begin
                walk_chan++;
            end else begin
                walk_chan = CH_GREEN;
                if (walk_row + 1 < NUM_ROWS) begin
                    walk_row++;
                end else begin
                    walk_row = '0;
                    if (walk_col + 1 < NUM_COLUMNS) begin
                        walk_col++;
                    end else begin
                        walk_col   = '0;
                        walk_phase = PH_LATCH;
                    end
                end
            end
        end
    endfunction

    function automatic t_out_item chain_step(input t_in_item it);
        t_out_item  res;
        logic [7:0] pix_byte;
        logic       bit_v;
        int         hi;
        int         lo;
        int         lt;
        res = '0;
        case (it.func)
            FN_SET_LEVEL: begin
                if (walk_phase == PH_IDLE && it.column < NUM_COLUMNS && it.level <= NUM_ROWS) begin
                    lvl_mem[it.column] = it.level;
                    res.accepted = 1'b1;
                end
            end
            FN_START: begin
                if (walk_phase == PH_IDLE) begin
                    walk_phase = PH_SEND;
                    walk_col   = '0;
                    walk_row   = '0;
                    walk_chan  = CH_GREEN;
                    walk_bit   = '0;
                    tick_cnt   = '0;
                    res.accepted = 1'b1;
                end
            end
            FN_TICK: begin
                if (walk_phase == PH_SEND) begin
                    pix_byte = color_byte(walk_col, walk_row, walk_chan);
                    bit_v = pix_byte[3'd7 - walk_bit];
                    hi = bit_v ? int'(cfg_one_hi) : int'(cfg_zero_hi);
                    lo = bit_v ? int'(cfg_one_lo) : int'(cfg_zero_lo);
                    res.line_level = (int'(tick_cnt) < hi);
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= hi + lo) next_bit();
                end else if (walk_phase == PH_LATCH) begin
                    lt = (cfg_latch == 16'd0) ? 1 : int'(cfg_latch);
                    tick_cnt = tick_cnt + 16'd1;
                    if (int'(tick_cnt) >= lt) begin
                        tick_cnt   = '0;
                        walk_phase = PH_IDLE;
                        res.frame_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.busy_res = (walk_phase != PH_IDLE);
        return res;
    endfunction

    function automatic t_in_item mk_beat(input t_func fn, input logic [3:0] col,
                                         input logic [3:0] lvl);
        t_in_item it;
        it.func   = fn;
        it.column = col;
        it.level  = lvl;
        return it;
    endfunction

    function automatic t_in_item any_beat();
        return mk_beat(t_func'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)));
    endfunction

    function automatic t_in_item tick_beat();
        return mk_beat(FN_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    endfunction

    // While idle: level writes (some out of range), idle ticks and the unused code, never a start.
    function automatic t_in_item idle_beat(input int lvl_max);
        logic [3:0] lvl;
        case ($urandom_range(0, 3))
            0, 1: begin
                lvl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(NUM_ROWS + 1, 15))
                                                  : 4'($urandom_range(0, lvl_max));
                return mk_beat(FN_SET_LEVEL, 4'($urandom_range(0, 15)), lvl);
            end
            2: return tick_beat();
            default: return mk_beat(FN_NONE, 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
        endcase
    endfunction

    task automatic push_beat(input t_in_item it, input bit typed, input t_out_item typed_exp);
        int        gap;
        t_out_item pred;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        pred = chain_step(it);
        pending_status.push_back(typed ? typed_exp : pred);
    endtask

    task automatic push_pred(input t_in_item it);
        push_beat(it, 1'b0, '0);
    endtask

    task automatic cfg_read(input t_cfg_idx idx, input logic [31:0] exp);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== exp) begin
            flag_error($sformatf("register %s reads %0h, expected %0h", idx.name(), prdata, exp));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_cfg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_read(idx, val);
    endtask

    // The sender holds off until every status beat is back, then reprograms the block.
    task automatic set_regs(input int oh, input int ol, input int zh, input int zl,
                            input int lt, input int g, input int o);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        cfg_write(CFG_ONE_HIGH, oh);
        cfg_write(CFG_ONE_LOW, ol);
        cfg_write(CFG_ZERO_HIGH, zh);
        cfg_write(CFG_ZERO_LOW, zl);
        cfg_write(CFG_LATCH, lt);
        cfg_write(CFG_GREEN_ROWS, g);
        cfg_write(CFG_ORANGE_ROWS, o);
    endtask

    task automatic tick_until_idle();
        while (walk_phase != PH_IDLE) begin
            push_pred(($urandom_range(0, 23) == 0) ? any_beat() : tick_beat());
        end
    endtask

    task automatic tick_burst(input int n);
        for (int k = 0; (k < n) && (walk_phase != PH_IDLE); k++) begin
            push_pred(($urandom_range(0, 23) == 0) ? any_beat() : tick_beat());
        end
    endtask

    task automatic run_phase(input int lvl_max, input int n_idle, input bit with_frame);
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            push_pred(mk_beat(FN_SET_LEVEL, 4'(c), 4'($urandom_range(0, lvl_max))));
        end
        repeat (n_idle) push_pred(idle_beat(lvl_max));
        if (with_frame) begin
            push_pred(mk_beat(FN_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
            tick_until_idle();
        end
        repeat (5) push_pred(idle_beat(lvl_max));
    endtask

    initial begin
        int         gap;
        t_out_item  got;
        t_out_item  exp;
        out_if.ready = 1'b0;
        forever begin
            gap = draw_gap();
            @(negedge i_clk);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && i_rst_n));
            got = out_if.data;
            if (pending_status.size() == 0) begin
                flag_error($sformatf("status beat %b with none expected", got));
            end else begin
                exp = pending_status.pop_front();
                if (got.line_level !== exp.line_level)
                    flag_error($sformatf("line_level %b, expected %b", got.line_level,
                                         exp.line_level));
                if (got.busy_res !== exp.busy_res)
                    flag_error($sformatf("busy_res %b, expected %b", got.busy_res, exp.busy_res));
                if (got.frame_done !== exp.frame_done)
                    flag_error($sformatf("frame_done %b, expected %b", got.frame_done,
                                         exp.frame_done));
                if (got.accepted !== exp.accepted)
                    flag_error($sformatf("accepted %b, expected %b", got.accepted, exp.accepted));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        t_in_item beat;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        for (int c = 0; c < NUM_COLUMNS; c++) lvl_mem[c] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_read(CFG_ONE_HIGH, RST_ONE_HIGH);
        cfg_read(CFG_ONE_LOW, RST_ONE_LOW);
        cfg_read(CFG_ZERO_HIGH, RST_ZERO_HIGH);
        cfg_read(CFG_ZERO_LOW, RST_ZERO_LOW);
        cfg_read(CFG_LATCH, RST_LATCH);
        cfg_read(CFG_GREEN_ROWS, RST_GREEN_ROWS);
        cfg_read(CFG_ORANGE_ROWS, RST_ORANGE_ROWS);

        set_regs(2, 0, 1, 1, 3, 4, 8);
        run_phase(NUM_ROWS, 50, 1'b0);
        for (int k = 0; k < N_DIRECTED; k++) begin
            beat = mk_beat(DIRECTED[k].fn, DIRECTED[k].col, DIRECTED[k].lvl);
            push_beat(beat, DIRECTED[k].typed, DIRECTED[k].exp);
        end

        // A full frame is about 2400 bits, so most of it runs with one-tick bits.
        pace = 2;
        set_regs(3, 1, 1, 2, 3, 4, 8);
        tick_burst(100);

        pace = 1;
        set_regs(1, 0, 0, 0, 3, 6, 2);
        tick_burst(700);

        pace = 0;
        set_regs(1, 0, 0, 0, 0, 3, 7);
        tick_until_idle();
        run_phase(NUM_ROWS, 20, 1'b0);

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_status.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
